// File: src/query_text_tokenizer_core_assert.svh
// assertion macros for the tokenizer core, sampled on clk and quiet in reset
`ifndef QUERY_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define QUERY_TEXT_TOKENIZER_CORE_ASSERT_SVH

// condition that holds in the same cycle as its trigger
`define QTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition that holds in the cycle after its trigger
`define QTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/qtt_pkg.sv
`default_nettype none

package qtt_pkg;

  localparam int CNT_W  = 16;
  localparam int WIDE_W = CNT_W + 16;
  localparam logic [WIDE_W-1:0] WIDE_OUT_MAX = WIDE_W'(16'hFFFF);
  localparam logic [CNT_W-1:0] LEN_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] LEN_ZERO = CNT_W'(0);

  localparam logic [3:0] K_IDENT   = 4'd0;
  localparam logic [3:0] K_BOOL    = 4'd1;
  localparam logic [3:0] K_INT     = 4'd2;
  localparam logic [3:0] K_FLOAT   = 4'd3;
  localparam logic [3:0] K_STRING  = 4'd4;
  localparam logic [3:0] K_COLON   = 4'd5;
  localparam logic [3:0] K_SEMI    = 4'd6;
  localparam logic [3:0] K_COMMA   = 4'd7;
  localparam logic [3:0] K_LBRACK  = 4'd8;
  localparam logic [3:0] K_RBRACK  = 4'd9;
  localparam logic [3:0] K_LBRACE  = 4'd10;
  localparam logic [3:0] K_RBRACE  = 4'd11;
  localparam logic [3:0] K_ILLEGAL = 4'd12;
  localparam logic [3:0] K_EOF     = 4'd13;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keyword tracker: 1..4 walks "true", 5..9 walks "false"
  localparam logic [3:0] KW_NONE    = 4'd0;
  localparam logic [3:0] KW_T_START = 4'd1;
  localparam logic [3:0] KW_TRUE    = 4'd4;
  localparam logic [3:0] KW_F_START = 4'd5;
  localparam logic [3:0] KW_FALSE   = 4'd9;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_DASH    = 8'b0000_0010,
    M_COMMENT = 8'b0000_0100,
    M_IDENT   = 8'b0000_1000,
    M_INT     = 8'b0001_0000,
    M_FLOAT   = 8'b0010_0000,
    M_STR     = 8'b0100_0000,
    M_STR_ESC = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0" && b <= "9");
  endfunction

  function automatic logic is_ident_more(input logic [7:0] b);
    is_ident_more = is_alpha(b) || is_digit(b) || b == CH_US || b == CH_DOLLAR ||
                    b == CH_COLON || b == CH_AT || b == CH_LBRACK || b == CH_RBRACK;
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] b);
    logic [7:0] want;
    logic       live;
    live = 1'b1;
    case (p)
      4'd1: want = "r";
      4'd2: want = "u";
      4'd3: want = "e";
      4'd5: want = "a";
      4'd6: want = "l";
      4'd7: want = "s";
      4'd8: want = "e";
      default: begin
        want = 8'h00;
        live = 1'b0;
      end
    endcase
    kw_next = (live && b == want) ? p + 4'd1 : KW_NONE;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    sat_inc = (x == {CNT_W{1'b1}}) ? x : x + LEN_ONE;
  endfunction

  function automatic logic [15:0] out16(input logic [CNT_W-1:0] x);
    logic [WIDE_W-1:0] w;
    w = {16'd0, x};
    out16 = (w > WIDE_OUT_MAX) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [CNT_W-1:0] span_len(input logic [CNT_W-1:0] stop,
                                                 input logic [CNT_W-1:0] start);
    span_len = (stop > start) ? stop - start : LEN_ZERO;
  endfunction

  function automatic result_t mk_res(input logic [3:0] kind, input logic [CNT_W-1:0] start,
                                     input logic [CNT_W-1:0] len,
                                     input logic [CNT_W-1:0] line,
                                     input logic [CNT_W-1:0] col);
    result_t r;
    r.kind   = kind;
    r.start  = out16(start);
    r.length = out16(len);
    r.line   = out16(line);
    r.column = out16(col);
    mk_res = r;
  endfunction

endpackage

`default_nettype wire

// File: src/qtt_scan.sv
`default_nettype none

module qtt_scan (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [7:0]       text_byte,
  input  wire logic             final_byte,
  output qtt_pkg::bundle_t      bundle
);

  localparam int CW = qtt_pkg::CNT_W;

  qtt_pkg::mode_t  mode, mode_next;
  logic            qd, qd_next;
  logic [CW-1:0]   off, off_next;
  logic [CW-1:0]   line, line_next;
  logic [CW-1:0]   col, col_next;
  logic [CW-1:0]   ts, ts_next;
  logic [CW-1:0]   tl, tl_next;
  logic [CW-1:0]   tc, tc_next;
  logic [3:0]      kp, kp_next;

  qtt_pkg::result_t cand [4];
  logic [3:0]       cv;
  logic             redo;
  logic [7:0]       q;
  logic [3:0]       id_kind;
  logic [3:0]       fin_kind;
  logic [3:0]       punct;
  logic             is_punct;
  logic [2:0]       n;

  always_comb begin
    mode_next = mode;
    qd_next   = qd;
    ts_next   = ts;
    tl_next   = tl;
    tc_next   = tc;
    kp_next   = kp;
    cv        = 4'b0000;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    redo     = 1'b0;
    q        = qd ? qtt_pkg::CH_DQ : qtt_pkg::CH_SQ;
    id_kind  = (kp == qtt_pkg::KW_TRUE || kp == qtt_pkg::KW_FALSE) ?
               qtt_pkg::K_BOOL : qtt_pkg::K_IDENT;
    fin_kind = qtt_pkg::K_IDENT;
    punct    = qtt_pkg::K_ILLEGAL;
    is_punct = 1'b0;

    // the byte against the token in progress
    case (mode)
      qtt_pkg::M_DASH: begin
        if (text_byte == qtt_pkg::CH_DASH) mode_next = qtt_pkg::M_COMMENT;
        else redo = 1'b1;
      end
      qtt_pkg::M_COMMENT: begin
        if (text_byte == qtt_pkg::CH_NL) mode_next = qtt_pkg::M_IDLE;
      end
      qtt_pkg::M_IDENT: begin
        if (qtt_pkg::is_ident_more(text_byte)) begin
          kp_next = qtt_pkg::kw_next(kp, text_byte);
        end else begin
          cv[0]   = 1'b1;
          cand[0] = qtt_pkg::mk_res(id_kind, ts, qtt_pkg::span_len(off, ts), tl, tc);
          redo    = 1'b1;
        end
      end
      qtt_pkg::M_INT: begin
        if (text_byte == qtt_pkg::CH_DOT) begin
          mode_next = qtt_pkg::M_FLOAT;
        end else if (!qtt_pkg::is_digit(text_byte)) begin
          cv[0]   = 1'b1;
          cand[0] = qtt_pkg::mk_res(qtt_pkg::K_INT, ts, qtt_pkg::span_len(off, ts), tl, tc);
          redo    = 1'b1;
        end
      end
      qtt_pkg::M_FLOAT: begin
        if (!qtt_pkg::is_digit(text_byte)) begin
          cv[0]   = 1'b1;
          cand[0] = qtt_pkg::mk_res(qtt_pkg::K_FLOAT, ts, qtt_pkg::span_len(off, ts), tl, tc);
          redo    = 1'b1;
        end
      end
      qtt_pkg::M_STR: begin
        if (text_byte == q) begin
          cv[0]     = 1'b1;
          cand[0]   = qtt_pkg::mk_res(qtt_pkg::K_STRING, ts, qtt_pkg::span_len(off, ts),
                                      tl, tc);
          mode_next = qtt_pkg::M_IDLE;
        end else if (text_byte == qtt_pkg::CH_BSL) begin
          mode_next = qtt_pkg::M_STR_ESC;
        end
      end
      qtt_pkg::M_STR_ESC: begin
        // an escaped quote is plain content; another backslash escapes again
        if (text_byte != q && text_byte == qtt_pkg::CH_BSL) mode_next = qtt_pkg::M_STR_ESC;
        else mode_next = qtt_pkg::M_STR;
      end
      default: redo = 1'b1;
    endcase

    case (text_byte)
      qtt_pkg::CH_COLON: begin punct = qtt_pkg::K_COLON;  is_punct = 1'b1; end
      qtt_pkg::CH_SEMI: begin punct = qtt_pkg::K_SEMI;   is_punct = 1'b1; end
      qtt_pkg::CH_COMMA: begin punct = qtt_pkg::K_COMMA;  is_punct = 1'b1; end
      qtt_pkg::CH_LBRACK: begin punct = qtt_pkg::K_LBRACK; is_punct = 1'b1; end
      qtt_pkg::CH_RBRACK: begin punct = qtt_pkg::K_RBRACK; is_punct = 1'b1; end
      qtt_pkg::CH_LBRACE: begin punct = qtt_pkg::K_LBRACE; is_punct = 1'b1; end
      qtt_pkg::CH_RBRACE: begin punct = qtt_pkg::K_RBRACE; is_punct = 1'b1; end
      default: begin punct = qtt_pkg::K_ILLEGAL; is_punct = 1'b0; end
    endcase

    // the byte seen from idle, also when it just ended a token
    if (redo) begin
      mode_next = qtt_pkg::M_IDLE;
      if (text_byte == qtt_pkg::CH_SPACE || text_byte == qtt_pkg::CH_TAB ||
          text_byte == qtt_pkg::CH_NL) begin
        mode_next = qtt_pkg::M_IDLE;
      end else if (text_byte == qtt_pkg::CH_DQ || text_byte == qtt_pkg::CH_SQ) begin
        // content starts after the opening quote
        mode_next = qtt_pkg::M_STR;
        qd_next   = (text_byte == qtt_pkg::CH_DQ);
        ts_next   = qtt_pkg::sat_inc(off);
        tl_next   = line;
        tc_next   = qtt_pkg::sat_inc(col);
      end else if (text_byte == qtt_pkg::CH_DASH) begin
        mode_next = qtt_pkg::M_DASH;
      end else if (is_punct) begin
        cv[1]   = 1'b1;
        cand[1] = qtt_pkg::mk_res(punct, off, qtt_pkg::LEN_ONE, line, col);
      end else if (qtt_pkg::is_alpha(text_byte) || text_byte == qtt_pkg::CH_US ||
                   text_byte == qtt_pkg::CH_DOLLAR) begin
        mode_next = qtt_pkg::M_IDENT;
        ts_next   = off;
        tl_next   = line;
        tc_next   = col;
        kp_next   = (text_byte == "t") ? qtt_pkg::KW_T_START :
                    (text_byte == "f") ? qtt_pkg::KW_F_START : qtt_pkg::KW_NONE;
      end else if (qtt_pkg::is_digit(text_byte)) begin
        mode_next = qtt_pkg::M_INT;
        ts_next   = off;
        tl_next   = line;
        tc_next   = col;
      end else begin
        cv[1]   = 1'b1;
        cand[1] = qtt_pkg::mk_res(qtt_pkg::K_ILLEGAL, off, qtt_pkg::LEN_ZERO, line, col);
      end
    end

    off_next = qtt_pkg::sat_inc(off);
    if (text_byte == qtt_pkg::CH_NL) begin
      line_next = qtt_pkg::sat_inc(line);
      col_next  = '0;
    end else begin
      line_next = line;
      col_next  = qtt_pkg::sat_inc(col);
    end

    if (final_byte) begin
      case (mode_next)
        qtt_pkg::M_IDENT: begin
          cv[2]    = 1'b1;
          fin_kind = (kp_next == qtt_pkg::KW_TRUE || kp_next == qtt_pkg::KW_FALSE) ?
                     qtt_pkg::K_BOOL : qtt_pkg::K_IDENT;
        end
        qtt_pkg::M_INT: begin cv[2] = 1'b1; fin_kind = qtt_pkg::K_INT; end
        qtt_pkg::M_FLOAT: begin cv[2] = 1'b1; fin_kind = qtt_pkg::K_FLOAT; end
        qtt_pkg::M_STR, qtt_pkg::M_STR_ESC: begin
          cv[2]    = 1'b1;
          fin_kind = qtt_pkg::K_STRING;
        end
        default: cv[2] = 1'b0;
      endcase
      cand[2] = qtt_pkg::mk_res(fin_kind, ts_next, qtt_pkg::span_len(off_next, ts_next),
                                tl_next, tc_next);
      cv[3]   = 1'b1;
      cand[3] = qtt_pkg::mk_res(qtt_pkg::K_EOF, off_next, qtt_pkg::LEN_ZERO, line_next,
                                col_next);
      mode_next = qtt_pkg::M_IDLE;
      qd_next   = 1'b0;
      off_next  = '0;
      line_next = '0;
      col_next  = '0;
      ts_next   = '0;
      tl_next   = '0;
      tc_next   = '0;
      kp_next   = qtt_pkg::KW_NONE;
    end

    // pack the tokens of this byte in order
    bundle = '0;
    n      = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && n < 3'd3) begin
        bundle.slot[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    bundle.count = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qtt_pkg::M_IDLE;
      qd   <= 1'b0;
      off  <= '0;
      line <= '0;
      col  <= '0;
      ts   <= '0;
      tl   <= '0;
      tc   <= '0;
      kp   <= qtt_pkg::KW_NONE;
    end else if (load) begin
      mode <= mode_next;
      qd   <= qd_next;
      off  <= off_next;
      line <= line_next;
      col  <= col_next;
      ts   <= ts_next;
      tl   <= tl_next;
      tc   <= tc_next;
      kp   <= kp_next;
    end
  end

endmodule

`default_nettype wire

// File: src/qtt_emit.sv
`default_nettype none

module qtt_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire qtt_pkg::bundle_t  bundle,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qtt_pkg::result_t       word,
  output logic                   last
);

  logic [1:0]        count;
  logic [1:0]        head;
  qtt_pkg::result_t  slots [3];

  assign out_valid = (count != 2'd0);
  assign last      = (head == count - 2'd1);
  assign word      = slots[head];
  // a new run may land in the cycle the last word of this one leaves
  assign free      = !out_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 2'd0;
    end else if (load) begin
      count <= bundle.count;
      head  <= 2'd0;
    end else if (out_valid && out_ready) begin
      if (last) begin
        count <= 2'd0;
        head  <= 2'd0;
      end else begin
        head <= head + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        slots[i] <= bundle.slot[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/query_text_tokenizer_core.sv
// Query text tokenizer: takes one text byte per word and returns one token per word, with
// offset, length, line and column clipped to 16 bits. A byte is taken in every cycle while
// out_ready is high and each byte yields at most one token; a byte that yields n tokens (up to
// three: an ended token, a punctuation or illegal token, and on the final byte the flushed
// token plus eof) keeps the input stalled until the token register has sent its n words, one
// per cycle while out_ready is high. run_end marks the last token of each byte. The scan
// state and position counters update in the cycle the byte is taken; no clearing is needed
// after reset.
`default_nettype none

module query_text_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [15:0]      token_length,
  output logic [15:0]      line_number,
  output logic [15:0]      column_number,
  output logic             run_end
);

  `include "query_text_tokenizer_core_assert.svh"

  qtt_pkg::bundle_t  bundle;
  qtt_pkg::result_t  word;
  logic              free;
  logic              load;

  assign in_ready = !rst && free;
  assign load     = in_valid && in_ready;

  qtt_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .bundle     (bundle)
  );

  qtt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word      (word),
    .last      (run_end)
  );

  assign token_kind    = word.kind;
  assign start_offset  = word.start;
  assign token_length  = word.length;
  assign line_number   = word.line;
  assign column_number = word.column;

  `QTT_ASSERT_NEXT(a_final_gives_eof, in_valid && in_ready && final_byte, out_valid, "final byte without a token")
  `QTT_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_end, out_valid, "token run cut short")
  `QTT_ASSERT_SAME(a_no_overrun, out_valid && !(out_ready && run_end), !in_ready, "byte taken while tokens pending")
  `QTT_ASSERT_SAME(a_eof_ends_run, out_valid && token_kind == qtt_pkg::K_EOF, run_end, "eof not last in run")

endmodule

`default_nettype wire
